// ===== src/alhpq_pkg.sv =====
// Shared types and register codes for the alarm line hold and press qualifier.
package alhpq_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_WINDOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_NEEDED  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPEATS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BUSY_EDGES    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_EDGES   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ARM_DELAY     = 3'd6;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic op;
        logic ignition_on;
    } item_t;

    typedef struct packed {
        logic hold_alert;
        logic press_alert;
        logic armed;
        logic signal_active;
    } result_t;

    typedef struct packed {
        logic [7:0]  hold_interval;
        logic [7:0]  press_window;
        logic [7:0]  press_needed;
        logic [7:0]  max_repeats;
        logic [15:0] busy_edges;
        logic [15:0] quiet_edges;
        logic [7:0]  arm_delay;
    } cfg_t;

endpackage

// ===== src/alarm_line_hold_and_press_qualifier_unit.sv =====
// Top level of the alarm line hold and press qualifier.
// Each request is an edge on the alarm line or a one-second tick carrying the
// ignition level, and each gives exactly one result: hold alert, press alert,
// armed and sustained-signal flags. The block takes one request per clock cycle
// while the result side does not stall. A taken request waits in the input
// register, then a single pass through the state update logic loads the result
// register when that register is free or being read. An empty input register
// takes the next request while a finished result waits, so throughput stays at one
// per cycle unless the result side stalls. Configuration writes are taken in
// any cycle but belong in idle periods.
module alarm_line_hold_and_press_qualifier_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  alhpq_pkg::item_t                  item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output alhpq_pkg::result_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [alhpq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [alhpq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import alhpq_pkg::*;

    cfg_t cfg;

    alhpq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    advance;

    assign advance      = !out_valid_reg || result_ready;
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    // Qualifier state
    logic [31:0] seconds_reg,     seconds_next;
    logic [15:0] edge_count_reg,  edge_count_next;
    logic        signal_reg,      signal_next;
    logic        latched_reg,     latched_next;
    logic [31:0] hold_start_reg,  hold_start_next;
    logic [7:0]  tally_reg,       tally_next;
    logic [31:0] press_start_reg, press_start_next;
    logic [7:0]  alerts_reg,      alerts_next;
    logic [7:0]  countdown_reg,   countdown_next;

    logic        process;
    result_t     result_next;
    logic [31:0] sec_inc;
    logic [31:0] press_age;
    logic [31:0] hold_age;
    logic [7:0]  tally_base;
    logic [7:0]  tally_inc;
    logic        busy;
    logic        pending;
    logic [7:0]  cd_mid;

    assign process   = in_valid_reg && advance;
    assign sec_inc   = seconds_reg + 32'd1;
    assign press_age = seconds_reg - press_start_reg;
    assign hold_age  = sec_inc - hold_start_reg;
    assign busy      = edge_count_reg >= cfg.busy_edges;

    always_comb
    begin
        seconds_next     = seconds_reg;
        edge_count_next  = edge_count_reg;
        signal_next      = signal_reg;
        latched_next     = latched_reg;
        hold_start_next  = hold_start_reg;
        tally_next       = tally_reg;
        press_start_next = press_start_reg;
        alerts_next      = alerts_reg;
        countdown_next   = countdown_reg;
        pending          = 1'b0;
        cd_mid           = countdown_reg;
        tally_base       = tally_reg;
        tally_inc        = tally_reg;
        result_next      = '0;

        if (in_item_reg.op == OP_EDGE)
        begin
            if (edge_count_reg != 16'hFFFF)
                edge_count_next = edge_count_reg + 16'd1;
            if (!latched_reg)
            begin
                latched_next    = 1'b1;
                hold_start_next = seconds_reg;
                // restart a stale press run
                tally_base = (press_age > {24'd0, cfg.press_window}) ? 8'd0 : tally_reg;
                if (tally_base == 8'd0)
                    press_start_next = seconds_reg;
                tally_inc = (tally_base != 8'hFF) ? tally_base + 8'd1 : tally_base;
                tally_next = tally_inc;
                // the run always lies within the window once the tally completes
                if (tally_inc >= cfg.press_needed)
                begin
                    result_next.press_alert = 1'b1;
                    tally_next = 8'd0;
                end
            end
        end
        else
        begin
            seconds_next    = sec_inc;
            edge_count_next = 16'd0;
            signal_next     = busy;
            if (!busy)
            begin
                if (edge_count_reg <= cfg.quiet_edges && !in_item_reg.ignition_on)
                    cd_mid = 8'd0;
                hold_start_next = sec_inc;
                alerts_next     = 8'd0;
                latched_next    = 1'b0;
            end
            else if (hold_age >= {24'd0, cfg.hold_interval} &&
                     alerts_reg < cfg.max_repeats)
            begin
                hold_start_next = sec_inc;
                pending         = 1'b1;
            end

            if (in_item_reg.ignition_on)
                countdown_next = cfg.arm_delay;
            else if (cd_mid != 8'd0)
                countdown_next = cd_mid - 8'd1;
            else
                countdown_next = cd_mid;

            // drop the queued alert unless armed
            if (countdown_next == 8'd0 && pending)
            begin
                if (alerts_reg != 8'hFF)
                    alerts_next = alerts_reg + 8'd1;
                result_next.hold_alert = 1'b1;
            end
        end

        result_next.armed         = countdown_next == 8'd0;
        result_next.signal_active = signal_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            seconds_reg     <= '0;
            edge_count_reg  <= '0;
            signal_reg      <= 1'b0;
            latched_reg     <= 1'b0;
            hold_start_reg  <= '0;
            tally_reg       <= '0;
            press_start_reg <= '0;
            alerts_reg      <= '0;
            countdown_reg   <= 8'd180;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (process)
            begin
                seconds_reg     <= seconds_next;
                edge_count_reg  <= edge_count_next;
                signal_reg      <= signal_next;
                latched_reg     <= latched_next;
                hold_start_reg  <= hold_start_next;
                tally_reg       <= tally_next;
                press_start_reg <= press_start_next;
                alerts_reg      <= alerts_next;
                countdown_reg   <= countdown_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_item_reg <= item;
        if (process)
            out_result_reg <= result_next;
    end

    // Checks
    a_hold_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hold_alert |-> result.armed)
        else $error("hold alert issued while not armed");

    a_one_alert_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.hold_alert && result.press_alert))
        else $error("hold and press alert in one result");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input stage lost a stalled request");

endmodule

// ===== src/alhpq_cfg.sv =====
// Configuration register file of the alarm line qualifier.
module alhpq_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [alhpq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [alhpq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output alhpq_pkg::cfg_t                 cfg
);
    import alhpq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD_INTERVAL: cfg_next.hold_interval = cfg_data[7:0];
                REG_PRESS_WINDOW:  cfg_next.press_window  = cfg_data[7:0];
                REG_PRESS_NEEDED:  cfg_next.press_needed  = cfg_data[7:0];
                REG_MAX_REPEATS:   cfg_next.max_repeats   = cfg_data[7:0];
                REG_BUSY_EDGES:    cfg_next.busy_edges    = cfg_data;
                REG_QUIET_EDGES:   cfg_next.quiet_edges   = cfg_data;
                REG_ARM_DELAY:     cfg_next.arm_delay     = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_interval <= 8'd4;
            cfg_reg.press_window  <= 8'd4;
            cfg_reg.press_needed  <= 8'd3;
            cfg_reg.max_repeats   <= 8'd3;
            cfg_reg.busy_edges    <= 16'd4;
            cfg_reg.quiet_edges   <= 16'd2;
            cfg_reg.arm_delay     <= 8'd180;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sim/tb_alarm_line_hold_and_press_qualifier_unit.sv =====
// Testbench for the alarm line hold and press qualifier: directed and random events checked against a predictor.
`timescale 1ns / 100ps

module tb_alarm_line_hold_and_press_qualifier_unit;
    import alhpq_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_PAUSE    = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam cfg_t CFG_AT_RESET = '{8'd4, 8'd4, 8'd3, 8'd3, 16'd4, 16'd2, 8'd180};

    // Tracks the qualifier state and holds the results still owed by the block.
    class alert_book;
        cfg_t        regs;
        bit [31:0]   sec_count;
        bit [15:0]   edge_tally;
        bit          sustained;
        bit          hold_latched;
        bit [31:0]   hold_since;
        bit [7:0]    press_count;
        bit [31:0]   press_since;
        bit [7:0]    alerts_done;
        bit [7:0]    arm_timer;
        bit          hold_queued;
        result_t     due_results[$];
        int unsigned bad_count;
        int unsigned checked;

        function new();
            regs         = CFG_AT_RESET;
            sec_count    = '0;
            edge_tally   = '0;
            sustained    = 1'b0;
            hold_latched = 1'b0;
            hold_since   = '0;
            press_count  = '0;
            press_since  = '0;
            alerts_done  = '0;
            arm_timer    = 8'd180;
            hold_queued  = 1'b0;
            bad_count    = 0;
            checked      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HOLD_INTERVAL: regs.hold_interval = data[7:0];
                REG_PRESS_WINDOW:  regs.press_window  = data[7:0];
                REG_PRESS_NEEDED:  regs.press_needed  = data[7:0];
                REG_MAX_REPEATS:   regs.max_repeats   = data[7:0];
                REG_BUSY_EDGES:    regs.busy_edges    = data;
                REG_QUIET_EDGES:   regs.quiet_edges   = data;
                REG_ARM_DELAY:     regs.arm_delay     = data[7:0];
                default: ;
            endcase
        endfunction

        function result_t qualify(item_t it);
            result_t   r;
            bit [31:0] span;
            r = '0;
            if (it.op == OP_EDGE) begin
                if (edge_tally != 16'hFFFF)
                    edge_tally++;
                // only the first edge of a hold counts as a press
                if (!hold_latched) begin
                    hold_latched = 1'b1;
                    hold_since   = sec_count;
                    span = sec_count - press_since;
                    if (span > regs.press_window)
                        press_count = '0;
                    if (press_count == 8'd0)
                        press_since = sec_count;
                    if (press_count != 8'hFF)
                        press_count++;
                    if (press_count >= regs.press_needed) begin
                        span = sec_count - press_since;
                        r.press_alert = (span <= regs.press_window);
                        press_count = '0;
                    end
                end
            end
            else begin
                sec_count++;
                // judge the second that just ended
                if (edge_tally >= regs.busy_edges) begin
                    sustained = 1'b1;
                end
                else begin
                    if (edge_tally <= regs.quiet_edges && !it.ignition_on)
                        arm_timer = '0;
                    sustained  = 1'b0;
                    hold_since = sec_count;
                end
                edge_tally = '0;
                if (sustained) begin
                    span = sec_count - hold_since;
                    if (span >= regs.hold_interval && alerts_done < regs.max_repeats) begin
                        hold_since  = sec_count;
                        hold_queued = 1'b1;
                    end
                end
                else begin
                    alerts_done  = '0;
                    hold_latched = 1'b0;
                end
                if (it.ignition_on)
                    arm_timer = regs.arm_delay;
                else if (arm_timer != 8'd0)
                    arm_timer--;
                // drop a queued alert unless armed
                if (arm_timer != 8'd0) begin
                    hold_queued = 1'b0;
                end
                else if (hold_queued) begin
                    hold_queued = 1'b0;
                    if (alerts_done != 8'hFF)
                        alerts_done++;
                    r.hold_alert = 1'b1;
                end
            end
            r.armed         = (arm_timer == 8'd0);
            r.signal_active = sustained;
            return r;
        endfunction

        function void take_event(item_t it);
            due_results.push_back(qualify(it));
        endfunction

        function void match_result(result_t got);
            result_t want;
            checked++;
            if (due_results.size() == 0) begin
                bad_count++;
                if (bad_count <= REPORT_LIMIT)
                    $display("result %0d: nothing expected, got %b", checked, got);
                return;
            end
            want = due_results.pop_front();
            if (got.hold_alert !== want.hold_alert || got.press_alert !== want.press_alert ||
                got.armed !== want.armed || got.signal_active !== want.signal_active) begin
                bad_count++;
                if (bad_count <= REPORT_LIMIT)
                    $display("result %0d: hold %b/%b press %b/%b armed %b/%b active %b/%b (exp/act)",
                             checked, want.hold_alert, got.hold_alert, want.press_alert,
                             got.press_alert, want.armed, got.armed, want.signal_active,
                             got.signal_active);
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    alert_book   book;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          items_done     = 0;
    logic        pressure_on    = 1'b0;
    bit          pressure_used  = 1'b0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    alarm_line_hold_and_press_qualifier_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Result side: random stalls, plus one long hold-off when pressure is requested.
    always @(posedge clk)
    begin
        if (pressure_on && !pressure_used) begin
            hold_left     = HOLD_OFF_LEN;
            pressure_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_ready)
            book.match_result(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready) ||
            (cfg_valid && cfg_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_event(input logic op, input logic ign);
        item_t it;
        it.op          = op;
        it.ignition_on = ign;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_ready !== 1'b1)
            @(posedge clk);
        book.take_event(it);
        items_done++;
    endtask

    task automatic send_second(input int n, input logic ign);
        repeat (n)
            send_event(OP_EDGE, 1'($urandom_range(0, 1)));
        send_event(OP_TICK, ign);
    endtask

    // One burst of well-formed seconds, or a little noise.
    task automatic send_run();
        int kind;
        int len;
        int busy_n;
        bit heavy;
        kind   = $urandom_range(0, 99);
        busy_n = int'(book.regs.busy_edges);
        heavy  = (busy_n <= 8);
        if (kind < 40) begin
            len = $urandom_range(1, 18);
            repeat (len)
                send_second(heavy ? $urandom_range(busy_n, busy_n + 2) : $urandom_range(0, 3),
                            ($urandom_range(0, 9) == 0));
        end
        else if (kind < 75) begin
            len = $urandom_range(1, 6);
            repeat (len)
                send_second($urandom_range(1, 2), ($urandom_range(0, 3) == 0));
        end
        else if (kind < 90) begin
            len = $urandom_range(1, 4);
            repeat (len)
                send_second($urandom_range(0, heavy ? busy_n + 1 : 3), 1'($urandom_range(0, 1)));
        end
        else begin
            repeat ($urandom_range(1, 4))
                send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        book.set_reg(idx, data);
    endtask

    // Junk goes in the upper byte of the narrow registers; the block must mask it.
    task automatic apply_settings(input cfg_t s);
        write_reg(REG_HOLD_INTERVAL, (16'($urandom_range(0, 255)) << 8) | 16'(s.hold_interval));
        write_reg(REG_PRESS_WINDOW,  (16'($urandom_range(0, 255)) << 8) | 16'(s.press_window));
        write_reg(REG_PRESS_NEEDED,  (16'($urandom_range(0, 255)) << 8) | 16'(s.press_needed));
        write_reg(REG_MAX_REPEATS,   (16'($urandom_range(0, 255)) << 8) | 16'(s.max_repeats));
        write_reg(REG_BUSY_EDGES,    s.busy_edges);
        write_reg(REG_QUIET_EDGES,   s.quiet_edges);
        write_reg(REG_ARM_DELAY,     (16'($urandom_range(0, 255)) << 8) | 16'(s.arm_delay));
        write_reg(REG_UNUSED,        16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_phase();
        item_valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE)
            @(posedge clk);
    endtask

    task automatic random_phase(input int budget);
        items_done = 0;
        while (items_done < budget)
            send_run();
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.hold_interval = 8'($urandom_range(0, 5));
        s.press_window  = 8'($urandom_range(1, 6));
        s.press_needed  = 8'($urandom_range(0, 4));
        s.max_repeats   = 8'($urandom_range(0, 4));
        s.busy_edges    = 16'($urandom_range(1, 6));
        s.quiet_edges   = 16'($urandom_range(0, 6));
        s.arm_delay     = 8'($urandom_range(0, 5));
        return s;
    endfunction

    initial
    begin
        book = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reload, arm on a quiet second, a press run, then a hold alert.
        send_event(OP_TICK, 1'b1);
        send_second(1, 1'b0);
        send_second(1, 1'b0);
        send_second(1, 1'b0);
        repeat (4)
            send_second(4, 1'b0);
        finish_phase();

        apply_settings(CFG_AT_RESET);
        random_phase(250);
        finish_phase();

        // Low values: every press fires, no hold alerts at all, arm delay of zero.
        send_gap_pct = 54;
        apply_settings('{8'd1, 8'd1, 8'd1, 8'd0, 16'd1, 16'd0, 8'd0});
        random_phase(250);
        finish_phase();

        // Highest values; the tally is clear here, so 255 presses in a row fire once.
        send_gap_pct = 0;
        apply_settings('{8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255});
        items_done = 0;
        repeat (255)
            send_second(1, 1'($urandom_range(0, 1)));
        while (items_done < 650)
            send_run();
        finish_phase();

        // Zero hold interval and zero press count.
        recv_stall_pct = 54;
        apply_settings('{8'd0, 8'd2, 8'd0, 8'd5, 16'd3, 16'd1, 8'd3});
        random_phase(250);
        finish_phase();

        send_gap_pct   = 13;
        recv_stall_pct = 13;
        apply_settings(random_settings());
        random_phase(200);
        finish_phase();

        // Hold off the result side while requests keep coming.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        apply_settings(random_settings());
        pressure_on <= 1'b1;
        random_phase(150);
        finish_phase();

        if (book.bad_count == 0 && book.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
